// ===== rtl/point_in_polygon_crossing_test_top_defines.svh =====
// Assertion macros for the point-in-polygon crossing test.
// Included by the top level; no other dependencies.
`ifndef POINT_IN_POLYGON_CROSSING_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PIPCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PIPCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pipct_pkg.sv =====
// Package for the point-in-polygon crossing test: coordinate widths, item
// structs and the edge setup function. No dependencies.
`timescale 1ns / 1ps

package pipct_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

	// vertex count saturates here; a ring needs this many to be a polygon
	localparam logic [1:0] TALLY_FULL = 2'd3;
	localparam logic [1:0] TALLY_NONE = 2'd0;
	localparam logic [1:0] TALLY_ONE  = 2'd1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;

	typedef struct packed {
		coord_t query_x;
		coord_t query_y;
		coord_t vertex_x;
		coord_t vertex_y;
		logic   first_vertex;
		logic   last_vertex;
	} pipct_in_t;

	typedef struct packed {
		logic inside_res;
		logic degenerate;
	} pipct_out_t;

	// per-item control carried down the pipe
	typedef struct packed {
		logic edge_en;   // edge from previous vertex exists
		logic close_en;  // closing edge to start vertex is tested
		logic new_poly;  // item opened a polygon, parity restarts
		logic last;      // item produces a result
		logic degen;     // result is a degenerate ring
	} pipct_flags_t;

	// edge operands, lower end subtracted out
	typedef struct packed {
		logic  en;
		diff_t dqx;
		diff_t dy;
		diff_t dx;
		diff_t dqy;
	} edge_diff_t;

	// Orders the edge by y relative to the ray and forms the four differences
	// of the cross-multiplied crossing test.
	function automatic edge_diff_t edge_setup(input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t qx, input coord_t qy);
		logic       a_up;
		logic       b_up;
		coord_t     xl;
		coord_t     yl;
		coord_t     xu;
		coord_t     yu;
		edge_diff_t r;
		a_up = (ay > qy);
		b_up = (by > qy);
		if (a_up) begin
			xl = bx; yl = by; xu = ax; yu = ay;
		end else begin
			xl = ax; yl = ay; xu = bx; yu = by;
		end
		r.en  = (a_up != b_up);
		r.dqx = DIFF_WIDTH'(qx) - DIFF_WIDTH'(xl);
		r.dy  = DIFF_WIDTH'(yu) - DIFF_WIDTH'(yl);
		r.dx  = DIFF_WIDTH'(xu) - DIFF_WIDTH'(xl);
		r.dqy = DIFF_WIDTH'(qy) - DIFF_WIDTH'(yl);
		return r;
	endfunction

endpackage

// ===== rtl/point_in_polygon_crossing_test_top.sv =====
// Even-odd point-in-polygon test on a streamed vertex ring.
// Uses pipct_pkg and point_in_polygon_crossing_test_top_defines.svh.
`timescale 1ns / 1ps

// Takes one vertex item per clock and returns one result item per polygon,
// on the vertex flagged last. The query point is sampled with the vertex that
// opens a polygon (first flag, or any vertex while no polygon is open).
// Each vertex tests the edge from the previous vertex against the horizontal
// ray going right from the query point; the last vertex also tests the
// closing edge. Crossings are found exactly by cross-multiplication, no
// division or rounding. Rings of fewer than three vertices return outside
// with the degenerate flag set.
// Throughput: one item per cycle. A vertex passes through the input register,
// then edge setup, multiply, and compare and parity into the result register.
// The four 33x33 multipliers of the multiply stage set the clock. Items that
// give no result never wait on the result port; the input stalls only once a
// result is held by a stall and the pipe behind it has filled.

module point_in_polygon_crossing_test_top
	import pipct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vertex_valid,
	output logic       vertex_stall,
	input  pipct_in_t  vertex_item,
	output logic       result_valid,
	input  logic       result_stall,
	output pipct_out_t result_item
);

`include "point_in_polygon_crossing_test_top_defines.svh"

	// ---------------- ring state, updated at accept ----------------
	coord_t     start_x_q, start_y_q;
	coord_t     prev_x_q, prev_y_q;
	coord_t     hold_qx_q, hold_qy_q;
	logic [1:0] tally_q;
	logic       parity_q;

	// ---------------- pipeline ----------------
	logic         v_s1, v_s2, v_s3;
	logic         rdy1, rdy2, rdy3;
	pipct_flags_t flg_s1, flg_s2, flg_s3;

	// stage 1: raw operands
	coord_t vx_s1, vy_s1, px_s1, py_s1, sx_s1, sy_s1, qx_s1, qy_s1;
	// stage 2: edge differences
	edge_diff_t ea_s2, eb_s2;
	// stage 3: products
	prod_t  la_s3, ra_s3, lb_s3, rb_s3;
	logic   ena_s3, enb_s3;

	// output register
	logic       res_valid_q;
	pipct_out_t res_q;

	logic       accept;
	logic       new_poly;
	logic [1:0] tally_nx;
	logic       out_free;
	logic       load_out;
	logic       leave3;
	logic       cross_a, cross_b;
	logic       par_edge;
	edge_diff_t ea_c, eb_c;

	// ---------------- handshake chain ----------------
	assign out_free     = !res_valid_q || !result_stall;
	assign rdy3         = !v_s3 || !flg_s3.last || out_free;
	assign rdy2         = !v_s2 || rdy3;
	assign rdy1         = !v_s1 || rdy2;
	assign vertex_stall = !rdy1;
	assign accept       = vertex_valid && rdy1;
	assign leave3       = v_s3 && rdy3;
	assign load_out     = v_s3 && flg_s3.last && out_free;

	// ---------------- front end ----------------
	assign new_poly = vertex_item.first_vertex || (tally_q == TALLY_NONE);

	always_comb begin
		if (new_poly)
			tally_nx = TALLY_ONE;
		else if (tally_q == TALLY_FULL)
			tally_nx = TALLY_FULL;
		else
			tally_nx = tally_q + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			hold_qx_q <= '0;
			hold_qy_q <= '0;
			tally_q   <= TALLY_NONE;
		end else if (accept) begin
			prev_x_q <= vertex_item.vertex_x;
			prev_y_q <= vertex_item.vertex_y;
			if (new_poly) begin
				start_x_q <= vertex_item.vertex_x;
				start_y_q <= vertex_item.vertex_y;
				hold_qx_q <= vertex_item.query_x;
				hold_qy_q <= vertex_item.query_y;
			end
			tally_q <= vertex_item.last_vertex ? TALLY_NONE : tally_nx;
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= accept;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: operands ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			vx_s1 <= vertex_item.vertex_x;
			vy_s1 <= vertex_item.vertex_y;
			px_s1 <= prev_x_q;
			py_s1 <= prev_y_q;
			sx_s1 <= start_x_q;
			sy_s1 <= start_y_q;
			qx_s1 <= new_poly ? vertex_item.query_x : hold_qx_q;
			qy_s1 <= new_poly ? vertex_item.query_y : hold_qy_q;
			flg_s1.edge_en  <= !new_poly;
			flg_s1.close_en <= vertex_item.last_vertex && (tally_nx == TALLY_FULL);
			flg_s1.new_poly <= new_poly;
			flg_s1.last     <= vertex_item.last_vertex;
			flg_s1.degen    <= vertex_item.last_vertex && (tally_nx != TALLY_FULL);
		end
	end

	// ---------------- stage 2: edge setup ----------------
	always_comb begin
		ea_c = edge_setup(px_s1, py_s1, vx_s1, vy_s1, qx_s1, qy_s1);
		eb_c = edge_setup(vx_s1, vy_s1, sx_s1, sy_s1, qx_s1, qy_s1);
		ea_c.en = ea_c.en && flg_s1.edge_en;
		eb_c.en = eb_c.en && flg_s1.close_en;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ea_s2  <= ea_c;
			eb_s2  <= eb_c;
			flg_s2 <= flg_s1;
		end
	end

	// ---------------- stage 3: cross products ----------------
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			la_s3  <= PROD_WIDTH'(ea_s2.dqx) * PROD_WIDTH'(ea_s2.dy);
			ra_s3  <= PROD_WIDTH'(ea_s2.dx) * PROD_WIDTH'(ea_s2.dqy);
			lb_s3  <= PROD_WIDTH'(eb_s2.dqx) * PROD_WIDTH'(eb_s2.dy);
			rb_s3  <= PROD_WIDTH'(eb_s2.dx) * PROD_WIDTH'(eb_s2.dqy);
			ena_s3 <= ea_s2.en;
			enb_s3 <= eb_s2.en;
			flg_s3 <= flg_s2;
		end
	end

	// ---------------- compare and parity ----------------
	// query strictly left of the crossing
	assign cross_a  = ena_s3 && (la_s3 < ra_s3);
	assign cross_b  = enb_s3 && (lb_s3 < rb_s3);
	assign par_edge = (flg_s3.new_poly ? 1'b0 : parity_q) ^ cross_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (leave3) begin
			parity_q <= flg_s3.last ? 1'b0 : par_edge;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.inside_res <= !flg_s3.degen && (par_edge ^ cross_b);
			res_q.degenerate <= flg_s3.degen;
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

	// ---------------- assertions ----------------
	// a taken result leaves unless a new one is loaded behind it
	`PIPCT_ASSERT_NEXT(a_res_drain, clk, arst_n,
		res_valid_q && !result_stall && !load_out, !res_valid_q,
		"result held after it was taken")
	// a closing vertex leaves parity cleared for the next ring
	`PIPCT_ASSERT_NEXT(a_par_clear, clk, arst_n,
		leave3 && flg_s3.last, !parity_q, "parity not cleared after ring close")
	// an accepted vertex without the last flag keeps a polygon open
	`PIPCT_ASSERT_NEXT(a_ring_open, clk, arst_n,
		accept && !vertex_item.last_vertex, tally_q != TALLY_NONE,
		"ring closed without a last vertex")

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for point_in_polygon_crossing_test_top: streams vertex rings and checks each
// inside/degenerate verdict against an in-bench even-odd crossing predictor.
// Depends on pipct_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
	import pipct_pkg::*;

	// Q16.16 constants
	localparam coord_t ONE  = 32'sh0001_0000;
	localparam coord_t CMIN = 32'sh8000_0000;
	localparam coord_t CMAX = 32'sh7FFF_FFFF;

	// result-side back-pressure modes
	typedef enum int {RX_FREE, RX_SOME, RX_HEAVY} rx_mode_t;

	// after the last expected verdict, leave margin to watch for stray results
	localparam int DRAIN_CYCLES = 12;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       vertex_valid = 1'b0;
	logic       vertex_stall;
	pipct_in_t  vertex_item  = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	pipct_out_t result_item;

	point_in_polygon_crossing_test_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex_item  (vertex_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Ring predictor state: mirrors what the block must hold per polygon.
	// ------------------------------------------------------------------
	coord_t     ring_start_x, ring_start_y;
	coord_t     ring_prev_x, ring_prev_y;
	coord_t     ring_query_x, ring_query_y;
	logic       crossing_parity;
	logic [1:0] ring_count;

	pipct_out_t expected_verdicts[$];

	int         error_count      = 0;
	int         items_sent       = 0;
	int         rings_closed     = 0;
	int         rings_inside     = 0;
	int         rings_degenerate = 0;

	bit         tx_gaps = 1'b1;
	rx_mode_t   rx_mode = RX_SOME;

	// Does edge a-b cross the ray going right from q? Exact: products of 33-bit
	// differences fit the package's product width, so no division and no rounding.
	function automatic logic ray_hits(input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t qx, input coord_t qy);
		prod_t lo_x, lo_y, up_x, up_y, q_x, q_y, lhs, rhs;
		if ((ay > qy) == (by > qy))
			return 1'b0;
		if (ay > qy) begin
			up_x = PROD_WIDTH'(ax); up_y = PROD_WIDTH'(ay);
			lo_x = PROD_WIDTH'(bx); lo_y = PROD_WIDTH'(by);
		end else begin
			up_x = PROD_WIDTH'(bx); up_y = PROD_WIDTH'(by);
			lo_x = PROD_WIDTH'(ax); lo_y = PROD_WIDTH'(ay);
		end
		q_x = PROD_WIDTH'(qx);
		q_y = PROD_WIDTH'(qy);
		lhs = (q_x - lo_x) * (up_y - lo_y);
		rhs = (up_x - lo_x) * (q_y - lo_y);
		return lhs < rhs;
	endfunction

	// Advance the ring state with one accepted vertex; queue a verdict on a last vertex.
	task automatic predict_vertex(input pipct_in_t v);
		pipct_out_t verdict;
		// a first flag, or any vertex with no ring open, starts a ring
		if (v.first_vertex || ring_count == TALLY_NONE) begin
			ring_query_x    = v.query_x;
			ring_query_y    = v.query_y;
			ring_start_x    = v.vertex_x;
			ring_start_y    = v.vertex_y;
			ring_prev_x     = v.vertex_x;
			ring_prev_y     = v.vertex_y;
			crossing_parity = 1'b0;
			ring_count      = TALLY_ONE;
		end else begin
			crossing_parity ^= ray_hits(ring_prev_x, ring_prev_y, v.vertex_x, v.vertex_y,
				ring_query_x, ring_query_y);
			ring_prev_x = v.vertex_x;
			ring_prev_y = v.vertex_y;
			if (ring_count != TALLY_FULL)
				ring_count++;
		end
		if (v.last_vertex) begin
			if (ring_count != TALLY_FULL) begin
				verdict.inside_res = 1'b0;
				verdict.degenerate = 1'b1;
			end else begin
				// closing edge back to the start vertex
				verdict.inside_res = crossing_parity ^ ray_hits(v.vertex_x, v.vertex_y,
					ring_start_x, ring_start_y, ring_query_x, ring_query_y);
				verdict.degenerate = 1'b0;
			end
			expected_verdicts = {expected_verdicts, verdict};
			ring_count      = TALLY_NONE;
			crossing_parity = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	// Idle run length: mostly none or short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic pipct_in_t vtx(input coord_t qx, input coord_t qy,
			input coord_t vx, input coord_t vy, input bit f, input bit l);
		pipct_in_t v;
		v.query_x      = qx;
		v.query_y      = qy;
		v.vertex_x     = vx;
		v.vertex_y     = vy;
		v.first_vertex = f;
		v.last_vertex  = l;
		return v;
	endfunction

	// Send one item: optional gap (junk payload while valid is low), then hold
	// valid until an edge with no stall. Called and returns at a falling edge.
	task automatic send_vertex(input pipct_in_t v);
		int gap;
		gap = tx_gaps ? idle_len() : 0;
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) begin
				vertex_item <= {$urandom, $urandom, $urandom, $urandom, 2'($urandom)};
				@(negedge clk);
			end
		end
		vertex_item  <= v;
		vertex_valid <= 1'b1;
		@(posedge clk);
		while (vertex_stall)
			@(posedge clk);
		predict_vertex(v);
		items_sent++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall runs, level picked by the current mode.
	// ------------------------------------------------------------------
	int   rx_run   = 0;
	logic rx_level = 1'b0;

	always @(negedge clk) begin
		if (rx_run == 0) begin
			rx_run = idle_len() + 1;
			case (rx_mode)
				RX_FREE:  rx_level = 1'b0;
				RX_SOME:  rx_level = ($urandom_range(0, 2) == 0);
				default:  rx_level = ($urandom_range(0, 3) != 0);
			endcase
		end
		rx_run--;
		result_stall <= rx_level;
	end

	// Every accepted result is matched against the oldest queued verdict.
	always @(posedge clk) begin : check_results
		pipct_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch($sformatf("result with none expected (inside %0b degenerate %0b)",
					result_item.inside_res, result_item.degenerate));
			end else begin
				want = expected_verdicts.pop_front();
				rings_closed++;
				if (want.inside_res) rings_inside++;
				if (want.degenerate) rings_degenerate++;
				if (result_item.inside_res !== want.inside_res)
					report_mismatch($sformatf("ring %0d inside_res %b, expected %b",
						rings_closed, result_item.inside_res, want.inside_res));
				if (result_item.degenerate !== want.degenerate)
					report_mismatch($sformatf("ring %0d degenerate %b, expected %b",
						rings_closed, result_item.degenerate, want.degenerate));
			end
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// 4x4 square: query in the middle, then off to the right on a side's span
	task automatic test_square();
		send_vertex(vtx(2*ONE, 2*ONE, 0, 0, 1, 0));
		send_vertex(vtx(CMAX, CMIN, 4*ONE, 0, 0, 0));     // query ignored here
		send_vertex(vtx(0, 0, 4*ONE, 4*ONE, 0, 0));
		send_vertex(vtx(0, 0, 0, 4*ONE, 0, 1));
		send_vertex(vtx(5*ONE, 2*ONE, 0, 0, 1, 0));
		send_vertex(vtx(0, 0, 4*ONE, 0, 0, 0));
		send_vertex(vtx(0, 0, 4*ONE, 4*ONE, 0, 0));
		send_vertex(vtx(0, 0, 0, 4*ONE, 0, 1));
	endtask

	// rings too short to be polygons
	task automatic test_short_rings();
		send_vertex(vtx(ONE, ONE, 0, 0, 1, 1));           // first and last together
		send_vertex(vtx(ONE, ONE, 0, 0, 1, 0));
		send_vertex(vtx(ONE, ONE, 3*ONE, 3*ONE, 0, 1));   // two vertices
		send_vertex(vtx(ONE, ONE, 2*ONE, 0, 0, 1));       // last with no ring open
	endtask

	// dropped ring, then a ring opened without a first flag
	task automatic test_restart();
		send_vertex(vtx(ONE, ONE, -5*ONE, -5*ONE, 1, 0));
		send_vertex(vtx(ONE, ONE, 5*ONE, -5*ONE, 0, 0));
		send_vertex(vtx(ONE, ONE, 0, 0, 1, 0));           // drops the open ring
		send_vertex(vtx(0, 0, 4*ONE, 0, 0, 0));
		send_vertex(vtx(0, 0, 0, 4*ONE, 0, 1));
		send_vertex(vtx(ONE, 3*ONE, 0, 0, 0, 0));         // no ring open: starts one
		send_vertex(vtx(0, 0, 4*ONE, 0, 0, 0));
		send_vertex(vtx(0, 0, 0, 4*ONE, 0, 1));
	endtask

	// full-range corners, horizontal edges on the ray, query on the boundary
	task automatic test_extremes();
		send_vertex(vtx(0, 0, CMIN, CMIN, 1, 0));
		send_vertex(vtx(0, 0, CMAX, CMIN, 0, 0));
		send_vertex(vtx(0, 0, CMAX, CMAX, 0, 0));
		send_vertex(vtx(0, 0, CMIN, CMAX, 0, 1));
		send_vertex(vtx(CMIN, CMIN, CMIN, CMIN, 1, 0));   // query on a corner
		send_vertex(vtx(0, 0, CMAX, CMIN, 0, 0));
		send_vertex(vtx(0, 0, CMIN, CMAX, 0, 1));
		send_vertex(vtx(-ONE, ONE, CMAX, ONE, 1, 0));     // horizontal edge at query y
		send_vertex(vtx(0, 0, CMIN, ONE, 0, 0));
		send_vertex(vtx(0, 0, 0, CMAX, 0, 1));
	endtask

	// ------------------------------------------------------------------
	// Random rings
	// ------------------------------------------------------------------

	// coordinate near a center on a coarse grid (so y values repeat and rays
	// graze vertices), sometimes an extreme, sometimes anything at all
	function automatic coord_t near(input coord_t c, input bit wide);
		int r;
		r = $urandom_range(0, 31);
		if (wide) return coord_t'($urandom);
		if (r == 0) return CMIN;
		if (r == 1) return CMAX;
		return c + coord_t'((int'($urandom_range(0, 16)) - 8) * 32'sh8000);
	endfunction

	// one ring of n vertices; a noisy ring gets misplaced or missing flags
	task automatic send_ring(input int n, input bit noisy);
		coord_t    cx, cy, qx, qy;
		bit        wide, f, l;
		pipct_in_t v;
		wide = ($urandom_range(0, 7) == 0);
		cx   = $urandom;
		cy   = $urandom;
		qx   = near(cx, wide);
		qy   = near(cy, wide);
		for (int i = 0; i < n; i++) begin
			f = (i == 0);
			l = (i == n - 1);
			if (noisy) begin
				f = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0);
				l = (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0);
			end
			v = vtx(qx, qy, near(cx, wide), near(cy, wide), f, l);
			if (i != 0) begin
				// query fields only count on the opening vertex
				v.query_x = $urandom;
				v.query_y = $urandom;
			end
			send_vertex(v);
		end
	endtask

	task automatic run_rings(input int count);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop)
			send_ring(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9),
				($urandom_range(0, 5) == 0));
	endtask

	task automatic test_random_traffic();
		tx_gaps = 1'b1;
		rx_mode = RX_SOME;
		run_rings(250);
	endtask

	// full rate both ways: one item per cycle with no stall
	task automatic test_back_to_back();
		tx_gaps = 1'b0;
		rx_mode = RX_FREE;
		run_rings(150);
	endtask

	// full-rate input against a mostly stalled output, so the pipe fills
	// and the input stall is exercised
	task automatic test_stalled_output();
		tx_gaps = 1'b0;
		rx_mode = RX_HEAVY;
		run_rings(150);
		tx_gaps = 1'b1;
		rx_mode = RX_SOME;
		run_rings(100);
	endtask

	// ------------------------------------------------------------------
	// Sequence: reset, directed, random, drain, verdict.
	// ------------------------------------------------------------------
	initial begin
		ring_start_x    = '0;
		ring_start_y    = '0;
		ring_prev_x     = '0;
		ring_prev_y     = '0;
		ring_query_x    = '0;
		ring_query_y    = '0;
		crossing_parity = 1'b0;
		ring_count      = TALLY_NONE;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_square();
		test_short_rings();
		test_restart();
		test_extremes();
		test_random_traffic();
		test_back_to_back();
		test_stalled_output();

		// all sent: let outstanding verdicts arrive, then watch for strays
		vertex_valid <= 1'b0;
		rx_mode = RX_SOME;
		while (expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d vertex items sent, %0d rings closed (%0d inside, %0d degenerate)",
			items_sent, rings_closed, rings_inside, rings_degenerate);
		$display("covered short, dropped and restarted rings, full-range corners, "
			, "full-rate and stalled phases");
		if (error_count == 0)
			$display("PASS point_in_polygon_crossing_test_top");
		else
			$display("FAIL point_in_polygon_crossing_test_top");
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("FAIL point_in_polygon_crossing_test_top");
		$finish;
	end

endmodule
